// ===== hw/rtl/cdt_pkg.sv =====
package cdt_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [3:0] {
      OP_LOAD        = 4'd0,
      OP_START       = 4'd1,
      OP_PAUSE       = 4'd2,
      OP_RESET       = 4'd3,
      OP_CHECK_DONE  = 4'd4,
      OP_ADJUST      = 4'd5,
      OP_NEXT_FIELD  = 4'd6,
      OP_ALARM_START = 4'd7,
      OP_ALARM_STOP  = 4'd8,
      OP_ALARM_POLL  = 4'd9,
      OP_QUERY       = 4'd10
   } opcode_type;

   // register indexes on the csr channel
   typedef enum logic [3:0] {
      REG_BEEP_GAP    = 4'd0,
      REG_ALARM_LIMIT = 4'd1
   } reg_index_type;

   // edit field selector codes
   localparam logic [1:0] FIELD_HOURS   = 2'd0;
   localparam logic [1:0] FIELD_MINUTES = 2'd1;
   localparam logic [1:0] FIELD_SECONDS = 2'd2;

   localparam logic [6:0]  MAX_HOURS        = 7'd99;
   localparam logic [6:0]  MAX_MIN_SEC      = 7'd59;
   localparam logic [28:0] MS_PER_HOUR      = 29'd3600000;
   localparam logic [28:0] MS_PER_MINUTE    = 29'd60000;
   localparam logic [28:0] MS_PER_SECOND    = 29'd1000;
   localparam logic [28:0] MIN_DURATION_MS  = 29'd1000;

   localparam logic [6:0]  HOURS_RESET      = 7'd0;
   localparam logic [5:0]  MINUTES_RESET    = 6'd5;
   localparam logic [5:0]  SECONDS_RESET    = 6'd0;
   localparam logic [15:0] BEEP_GAP_RESET   = 16'd1200;
   localparam logic [19:0] ALARM_LIMIT_RESET = 20'd30000;

   typedef struct packed {
      opcode_type         opcode;
      logic [31:0]        now_ms;
      logic signed [7:0]  step;
      logic               restore;
      logic               event_accepted;
   } req_item_type;

   typedef struct packed {
      logic [31:0] remaining_ms;
      logic [28:0] total_ms;
      logic        running;
      logic [6:0]  hours_set;
      logic [5:0]  minutes_set;
      logic [5:0]  seconds_set;
      logic [1:0]  edit_field;
      logic        done_request;
      logic        beep;
      logic        alarm_expired;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] beep_gap_ms;
      logic [19:0] alarm_limit_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/cdt_cfg.sv =====
module cdt_cfg (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [31:0]         csr_data,
   output cdt_pkg::cfg_type    cfg
);

   logic [15:0] beep_gap_ff, beep_gap_in;
   logic [19:0] alarm_limit_ff, alarm_limit_in;
   logic        write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      beep_gap_in    = beep_gap_ff;
      alarm_limit_in = alarm_limit_ff;
      if (write) begin
         case (csr_index)
            cdt_pkg::REG_BEEP_GAP:    beep_gap_in    = csr_data[15:0];
            cdt_pkg::REG_ALARM_LIMIT: alarm_limit_in = csr_data[19:0];
            default: ;  // writes beyond the map are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_gap_ff    <= cdt_pkg::BEEP_GAP_RESET;
         alarm_limit_ff <= cdt_pkg::ALARM_LIMIT_RESET;
      end else begin
         beep_gap_ff    <= beep_gap_in;
         alarm_limit_ff <= alarm_limit_in;
      end
   end

   assign cfg.beep_gap_ms    = beep_gap_ff;
   assign cfg.alarm_limit_ms = alarm_limit_ff;

endmodule

// ===== hw/rtl/cdt_core.sv =====
module cdt_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  cdt_pkg::req_item_type  item,
   input  cdt_pkg::cfg_type       cfg,
   output cdt_pkg::rsp_item_type  result
);

   logic [6:0]  hours_ff, hours_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [5:0]  seconds_ff, seconds_in;
   logic [1:0]  field_ff, field_in;
   logic [28:0] duration_ff, duration_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] end_ff, end_in;
   logic        counting_ff, counting_in;
   logic [31:0] last_beep_ff, last_beep_in;
   logic [31:0] alarm_begin_ff, alarm_begin_in;

   logic        done, beep, expired;
   logic [6:0]  adj_hours;
   logic [6:0]  adj_minutes_wide, adj_seconds_wide;
   logic [5:0]  adj_minutes, adj_seconds;
   logic [31:0] now;

   function automatic logic [6:0] clamp_add(input logic [6:0] v, input logic signed [7:0] d,
                                            input logic [6:0] hi);
      logic signed [9:0] s;
      logic [6:0]        r;
      s = $signed({3'b000, v}) + $signed({{2{d[7]}}, d});
      if (s < 10'sd0)
         r = 7'd0;
      else if (s > $signed({3'b000, hi}))
         r = hi;
      else
         r = s[6:0];
      return r;
   endfunction

   function automatic logic [28:0] duration_of(input logic [6:0] h, input logic [5:0] m,
                                               input logic [5:0] s);
      logic [28:0] ms;
      ms = 29'(h) * cdt_pkg::MS_PER_HOUR + 29'(m) * cdt_pkg::MS_PER_MINUTE
         + 29'(s) * cdt_pkg::MS_PER_SECOND;
      if (ms == 29'd0)
         ms = cdt_pkg::MIN_DURATION_MS;
      return ms;
   endfunction

   // plain unsigned compare against the end stamp, not wrap-aware
   function automatic logic [31:0] until_end(input logic [31:0] t, input logic [31:0] e);
      return (t >= e) ? 32'd0 : e - t;
   endfunction

   assign now = item.now_ms;

   always_comb begin
      hours_in       = hours_ff;
      minutes_in     = minutes_ff;
      seconds_in     = seconds_ff;
      field_in       = field_ff;
      duration_in    = duration_ff;
      left_in        = left_ff;
      end_in         = end_ff;
      counting_in    = counting_ff;
      last_beep_in   = last_beep_ff;
      alarm_begin_in = alarm_begin_ff;
      done           = 1'b0;
      beep           = 1'b0;
      expired        = 1'b0;

      adj_hours        = hours_ff;
      adj_minutes_wide = {1'b0, minutes_ff};
      adj_seconds_wide = {1'b0, seconds_ff};
      case (field_ff)
         cdt_pkg::FIELD_HOURS:
            adj_hours = clamp_add(hours_ff, item.step, cdt_pkg::MAX_HOURS);
         cdt_pkg::FIELD_MINUTES:
            adj_minutes_wide = clamp_add({1'b0, minutes_ff}, item.step, cdt_pkg::MAX_MIN_SEC);
         default:  // the unused selector code edits seconds too
            adj_seconds_wide = clamp_add({1'b0, seconds_ff}, item.step, cdt_pkg::MAX_MIN_SEC);
      endcase
      adj_minutes = adj_minutes_wide[5:0];
      adj_seconds = adj_seconds_wide[5:0];

      case (item.opcode)
         cdt_pkg::OP_LOAD: begin
            duration_in = duration_of(hours_ff, minutes_ff, seconds_ff);
            left_in     = 32'(duration_in);
         end
         cdt_pkg::OP_START: begin
            end_in      = now + left_ff;
            counting_in = 1'b1;
         end
         cdt_pkg::OP_PAUSE: begin
            left_in     = until_end(now, end_ff);
            counting_in = 1'b0;
         end
         cdt_pkg::OP_RESET: begin
            counting_in = 1'b0;
            left_in     = 32'(duration_ff);
         end
         cdt_pkg::OP_CHECK_DONE: begin
            if (counting_ff && now >= end_ff) begin
               done = 1'b1;
               if (item.event_accepted) begin
                  counting_in = 1'b0;
                  left_in     = 32'd0;
               end
            end
         end
         cdt_pkg::OP_ADJUST: begin
            hours_in    = adj_hours;
            minutes_in  = adj_minutes;
            seconds_in  = adj_seconds;
            duration_in = duration_of(adj_hours, adj_minutes, adj_seconds);
            left_in     = 32'(duration_in);
         end
         cdt_pkg::OP_NEXT_FIELD: begin
            case (field_ff)
               cdt_pkg::FIELD_HOURS:   field_in = cdt_pkg::FIELD_MINUTES;
               cdt_pkg::FIELD_MINUTES: field_in = cdt_pkg::FIELD_SECONDS;
               default:                field_in = cdt_pkg::FIELD_HOURS;
            endcase
         end
         cdt_pkg::OP_ALARM_START: begin
            alarm_begin_in = now;
            last_beep_in   = 32'd0;
         end
         cdt_pkg::OP_ALARM_STOP: begin
            if (item.restore)
               left_in = 32'(duration_ff);
         end
         cdt_pkg::OP_ALARM_POLL: begin
            if ((now - last_beep_ff) > 32'(cfg.beep_gap_ms)) begin
               beep         = 1'b1;
               last_beep_in = now;
            end
            expired = (now - alarm_begin_ff) > 32'(cfg.alarm_limit_ms);
         end
         default: ;  // query and unused codes leave the state alone
      endcase

      result.remaining_ms  = counting_in ? until_end(now, end_in) : left_in;
      result.total_ms      = duration_in;
      result.running       = counting_in;
      result.hours_set     = hours_in;
      result.minutes_set   = minutes_in;
      result.seconds_set   = seconds_in;
      result.edit_field    = field_in;
      result.done_request  = done;
      result.beep          = beep;
      result.alarm_expired = expired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff       <= cdt_pkg::HOURS_RESET;
         minutes_ff     <= cdt_pkg::MINUTES_RESET;
         seconds_ff     <= cdt_pkg::SECONDS_RESET;
         field_ff       <= cdt_pkg::FIELD_MINUTES;
         duration_ff    <= 29'd0;
         left_ff        <= 32'd0;
         end_ff         <= 32'd0;
         counting_ff    <= 1'b0;
         last_beep_ff   <= 32'd0;
         alarm_begin_ff <= 32'd0;
      end else if (item_valid) begin
         hours_ff       <= hours_in;
         minutes_ff     <= minutes_in;
         seconds_ff     <= seconds_in;
         field_ff       <= field_in;
         duration_ff    <= duration_in;
         left_ff        <= left_in;
         end_ff         <= end_in;
         counting_ff    <= counting_in;
         last_beep_ff   <= last_beep_in;
         alarm_begin_ff <= alarm_begin_in;
      end
   end

endmodule

// ===== hw/rtl/countdown_timer_with_alarm_unit.sv =====
// Countdown timer with alarm pacing, driven by timestamped operations.
// req channel: one operation per item; opcode in req_tuser, the current
// millisecond stamp, adjust step and the two flags in req_tdata.
// rsp channel: exactly one status item per operation, in order: remaining
// and full duration, running flag, set hours/minutes/seconds, edit field,
// and the done, beep and alarm-expired flags.
// csr channel: register 0 beep gap (16 bit), register 1 alarm limit
// (20 bit); always ready. The user must write it only while no operation
// is in flight; the block does not enforce this. An accepted item passes
// the input register, then the result register, which raises rsp_tvalid.
// Throughput: one item per cycle when the output does not stall; the timer
// state updates as the item moves from the input into the result register.
// When rsp_tready is low the result register holds; the input register still
// takes one more item, after which req_tready drops until the result moves.
// Reset (synchronous) empties both registers, restores the 0:05:00 setting,
// stops the countdown and loads the default beep gap and alarm limit.
module countdown_timer_with_alarm_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], step[39:32], restore[40], event_accepted[41], zero[47:42]
   input  logic [47:0] req_tdata,
   // opcode[3:0]
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // remaining_ms[31:0], total_ms[60:32], running[61], hours_set[68:62],
   // minutes_set[74:69], seconds_set[80:75], edit_field[82:81],
   // done_request[83], beep[84], alarm_expired[85], zero[87:86]
   output logic [87:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   cdt_pkg::cfg_type      cfg;
   cdt_pkg::req_item_type in_item_ff, in_item_in;
   cdt_pkg::rsp_item_type out_item_ff, result;
   logic                  in_valid_ff, in_valid_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  advance, req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.opcode         = cdt_pkg::opcode_type'(req_tuser);
      in_item_in.now_ms         = req_tdata[31:0];
      in_item_in.step           = $signed(req_tdata[39:32]);
      in_item_in.restore        = req_tdata[40];
      in_item_in.event_accepted = req_tdata[41];

      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   cdt_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cdt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_item_ff <= in_item_in;
      if (advance)
         out_item_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_item_ff.alarm_expired,
                        out_item_ff.beep,
                        out_item_ff.done_request,
                        out_item_ff.edit_field,
                        out_item_ff.seconds_set,
                        out_item_ff.minutes_set,
                        out_item_ff.hours_set,
                        out_item_ff.running,
                        out_item_ff.total_ms,
                        out_item_ff.remaining_ms};

endmodule

// ===== hw/rtl/cdt_checker.sv =====
module cdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);

   // nothing comes out in the cycle after a reset edge
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high straight after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed or dropped");

   a_edit_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[82:81] != 2'd3)
      else $error("edit field selector out of range");

   a_set_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[68:62] <= 7'd99 && rsp_tdata[74:69] <= 6'd59
                     && rsp_tdata[80:75] <= 6'd59)
      else $error("set time value outside its clamp range");

endmodule

bind countdown_timer_with_alarm_unit cdt_checker u_cdt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
